>>> design/stt_pkg.sv
// types, token codes and scan states shared by the tokenizer files
`timescale 1ns / 1ps
package stt_pkg;

    localparam int LEN_W = 16;

    typedef enum logic [3:0] {
        M_IDLE       = 4'd0,
        M_HOLD       = 4'd1,
        M_LINE       = 4'd2,
        M_BLOCK      = 4'd3,
        M_BLOCK_STAR = 4'd4,
        M_NUM        = 4'd5,
        M_NUM_DOT    = 4'd6,
        M_WORD       = 4'd7,
        M_STR        = 4'd8
    } t_mode;

    localparam logic [5:0] K_DOT     = 6'd25;
    localparam logic [5:0] K_SLASH   = 6'd31;
    localparam logic [5:0] K_UNKNOWN = 6'd46;
    localparam logic [5:0] K_EOF     = 6'd47;
    localparam logic [5:0] K_STRING  = 6'd48;
    localparam logic [5:0] K_FLOAT   = 6'd49;
    localparam logic [5:0] K_INTEGER = 6'd50;
    localparam logic [5:0] K_IDENT   = 6'd51;
    localparam logic [5:0] K_UNTERM  = 6'd52;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;
    localparam logic REC_TOKEN = 1'b0;
    localparam logic REC_VALUE = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] char_byte;
    } t_in;

    typedef struct packed {
        logic        record_kind;
        logic [5:0]  token_kind;
        logic [19:0] start_line;
        logic [15:0] start_column;
        logic [15:0] lexeme_length;
        logic [7:0]  value_byte;
        logic        last_of_run;
    } t_out;

    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {{(LEN_W-1){1'b0}}, b};
        return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [7:0] single_kind(input logic [7:0] c);
        unique case (c)
            "(": return 8'd16;
            ")": return 8'd17;
            "{": return 8'd18;
            "}": return 8'd19;
            "[": return 8'd20;
            "]": return 8'd21;
            ";": return 8'd22;
            ":": return 8'd23;
            ",": return 8'd24;
            ".": return 8'd25;
            "~": return 8'd26;
            "+": return 8'd27;
            "*": return 8'd30;
            "%": return 8'd32;
            "^": return 8'd45;
            default: return 8'd255;
        endcase
    endfunction

endpackage

>>> design/stt_keyword.sv
// keyword matcher: compares the buffered word against the sixteen keywords
`timescale 1ns / 1ps
module stt_keyword #(
    parameter int KEYWORD_BYTES = 6
) (
    input  logic [8*KEYWORD_BYTES-1:0] i_word,
    input  logic [15:0]                i_length,
    input  logic                       i_too_long,
    output logic [5:0]                 o_kind
);
    import stt_pkg::*;

    localparam int KB = KEYWORD_BYTES;

    // keyword text, first byte in the low bits, padded with zero
    function automatic logic [8*KB-1:0] kw(input int idx);
        logic [47:0] t;
        logic [8*KB-1:0] r;
        unique case (idx)
            0:  t = {24'd0, "tni"};
            1:  t = {8'd0, "taolf"};
            2:  t = "elbuod";
            3:  t = {16'd0, "loob"};
            4:  t = {16'd0, "rahc"};
            5:  t = {16'd0, "diov"};
            6:  t = "nruter";
            7:  t = {32'd0, "fi"};
            8:  t = {16'd0, "esle"};
            9:  t = {24'd0, "rof"};
            10: t = {8'd0, "elihw"};
            11: t = "tcurts";
            12: t = {16'd0, "mune"};
            13: t = {32'd0, "nf"};
            14: t = {16'd0, "eurt"};
            default: t = {8'd0, "eslaf"};
        endcase
        r = '0;
        r[47:0] = t;
        return r;
    endfunction

    localparam logic [2:0] KW_LEN [16] = '{3'd3, 3'd5, 3'd6, 3'd4, 3'd4, 3'd4, 3'd6, 3'd2,
                                           3'd4, 3'd3, 3'd5, 3'd6, 3'd4, 3'd2, 3'd4, 3'd5};

    always_comb begin
        o_kind = K_IDENT;
        if (!i_too_long && i_length <= 16'(KB)) begin
            for (int i = 15; i >= 0; i--) begin
                if (i_length == 16'(KW_LEN[i]) && i_word == kw(i)) begin
                    o_kind = 6'(i);
                end
            end
        end
    end

endmodule

>>> design/source_text_tokenizer.sv
// top level of the streaming c-style source tokenizer
`timescale 1ns / 1ps
// Streaming tokenizer for C-style source text. Each input item is a source
// byte or the end command; the results of each byte (up to three: decoded
// string byte or token records) are built by one pass of logic into a small
// result queue. Results leave one item per cycle while the receiver is
// ready, so a byte that causes two or three results holds off input while
// the queue drains; other bytes stream at one per cycle while it keeps up.
// Blanks and comments give no result. A quoted string sends its decoded
// bytes as value items, then its token record. The end command finishes any
// open token, sends the EOF token and returns the scanner state to reset.
// Line and column counts saturate at their widths.
module source_text_tokenizer #(
    parameter int LINE_WIDTH    = 20,
    parameter int COLUMN_WIDTH  = 16,
    parameter int KEYWORD_BYTES = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  stt_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output stt_pkg::t_out  o_data
);
    import stt_pkg::*;

    localparam int KB = KEYWORD_BYTES;
    localparam int KBW = $clog2(KB);
    localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_WIDTH-1:0] COL_MAX  = '1;

    // scanner state
    t_mode                   r_mode, n_mode;
    logic [7:0]              r_held, n_held;
    logic [LINE_WIDTH-1:0]   r_line, n_line, r_tline, n_tline;
    logic [COLUMN_WIDTH-1:0] r_col, n_col, r_tcol, n_tcol;
    logic [15:0]             r_len, n_len;
    logic [8*KB-1:0]         r_word, n_word;
    logic                    r_long, n_long, r_point, n_point;
    logic                    r_esc, n_esc, r_single, n_single;

    // result queue: up to three entries, r_cnt valid, head at index 0
    t_out       r_q [3];
    t_out       n_q [3];
    logic [1:0] r_cnt, n_cnt;

    // results of the current item
    t_out       res [3];
    logic [1:0] nres;

    logic       accept;
    logic [5:0] word_kind;

    stt_keyword #(.KEYWORD_BYTES(KB)) u_kw (
        .i_word    (r_word),
        .i_length  (r_len),
        .i_too_long(r_long),
        .o_kind    (word_kind)
    );

    // accept only when the queue is empty or its single item leaves this cycle
    assign o_ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);
    assign accept  = i_valid && o_ready;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_q[0];

    function automatic t_out mk(input logic rk, input logic [5:0] k,
                                input logic [LINE_WIDTH-1:0] ln,
                                input logic [COLUMN_WIDTH-1:0] cl,
                                input logic [15:0] len, input logic [7:0] vb);
        t_out o;
        o.record_kind   = rk;
        o.token_kind    = k;
        o.start_line    = 20'(ln);
        o.start_column  = 16'(cl);
        o.lexeme_length = len;
        o.value_byte    = vb;
        o.last_of_run   = 1'b0;
        return o;
    endfunction

    always_comb begin
        logic [7:0]              c;
        logic                    again;
        logic [7:0]              sk;
        logic [7:0]              second;
        logic [5:0]              two, one;
        logic [7:0]              d;
        logic [COLUMN_WIDTH:0]   dsum;
        logic [COLUMN_WIDTH-1:0] dcol;

        c = i_data.char_byte;
        again = 1'b0;
        sk = '0; second = '0; two = '0; one = '0; d = '0; dsum = '0; dcol = '0;
        n_mode = r_mode; n_held = r_held; n_line = r_line; n_col = r_col;
        n_tline = r_tline; n_tcol = r_tcol; n_len = r_len; n_word = r_word;
        n_long = r_long; n_point = r_point; n_esc = r_esc; n_single = r_single;
        res[0] = mk(REC_TOKEN, '0, '0, '0, '0, '0);
        res[1] = res[0];
        res[2] = res[0];
        nres = 2'd0;

        // held operator pairing
        unique case (r_held)
            "-": begin second = ">"; two = 6'd28; one = 6'd29; end
            "=": begin second = "="; two = 6'd33; one = 6'd34; end
            "!": begin second = "="; two = 6'd35; one = 6'd36; end
            "<": begin second = "="; two = 6'd37; one = 6'd38; end
            ">": begin second = "="; two = 6'd39; one = 6'd40; end
            "&": begin second = "&"; two = 6'd41; one = 6'd42; end
            "|": begin second = "|"; two = 6'd43; one = 6'd44; end
            "/": begin second = "/"; two = K_SLASH; one = K_SLASH; end
            default: begin second = '0; two = K_UNKNOWN; one = K_UNKNOWN; end
        endcase

        if (i_data.command == CMD_END) begin
            unique case (r_mode)
                M_HOLD: begin
                    res[0] = mk(REC_TOKEN, one, r_tline, r_tcol, 16'd1, '0);
                    nres = 2'd1;
                end
                M_NUM: begin
                    res[0] = mk(REC_TOKEN, r_point ? K_FLOAT : K_INTEGER, r_tline, r_tcol,
                                r_len, '0);
                    nres = 2'd1;
                end
                M_NUM_DOT: begin
                    res[0] = mk(REC_TOKEN, K_FLOAT, r_tline, r_tcol, sat_add(r_len, 2'd1), '0);
                    nres = 2'd1;
                end
                M_WORD: begin
                    res[0] = mk(REC_TOKEN, word_kind, r_tline, r_tcol, r_len, '0);
                    nres = 2'd1;
                end
                M_STR: begin
                    res[0] = mk(REC_TOKEN, K_UNTERM, r_tline, r_tcol, sat_add(r_len, 2'd1), '0);
                    nres = 2'd1;
                end
                default: ;
            endcase
            res[nres] = mk(REC_TOKEN, K_EOF, r_line, r_col, 16'd0, '0);
            nres = nres + 2'd1;
            n_mode = M_IDLE; n_held = '0; n_line = LINE_WIDTH'(1); n_col = COLUMN_WIDTH'(1);
            n_tline = LINE_WIDTH'(1); n_tcol = COLUMN_WIDTH'(1); n_len = '0; n_word = '0;
            n_long = 1'b0; n_point = 1'b0; n_esc = 1'b0; n_single = 1'b0;
        end else begin
            unique case (r_mode)
                M_IDLE: again = 1'b1;
                M_HOLD: begin
                    if (r_held == "/" && c == "/") begin
                        n_mode = M_LINE;
                    end else if (r_held == "/" && c == "*") begin
                        n_mode = M_BLOCK;
                    end else if (r_held != "/" && c == second) begin
                        res[0] = mk(REC_TOKEN, two, r_tline, r_tcol, 16'd2, '0);
                        nres = 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        res[0] = mk(REC_TOKEN, one, r_tline, r_tcol, 16'd1, '0);
                        nres = 2'd1;
                        again = 1'b1;
                    end
                end
                M_LINE: if (c == "\n") n_mode = M_IDLE;
                M_BLOCK: if (c == "*") n_mode = M_BLOCK_STAR;
                M_BLOCK_STAR: begin
                    if (c == "/") n_mode = M_IDLE;
                    else if (c != "*") n_mode = M_BLOCK;
                end
                M_NUM_DOT: begin
                    if (c == ".") begin
                        // integer then its held dot, then the new dot starts over
                        dsum = {1'b0, r_tcol} + (COLUMN_WIDTH+1)'(r_len);
                        dcol = (dsum > {1'b0, COL_MAX}) ? COL_MAX : dsum[COLUMN_WIDTH-1:0];
                        if (COLUMN_WIDTH < 16 && r_len > 16'(COL_MAX)) dcol = COL_MAX;
                        res[0] = mk(REC_TOKEN, K_INTEGER, r_tline, r_tcol, r_len, '0);
                        res[1] = mk(REC_TOKEN, K_DOT, r_tline, dcol, 16'd1, '0);
                        nres = 2'd2;
                        again = 1'b1;
                    end else begin
                        // dot joins the number; a digit extends the float, another byte ends it
                        n_point = 1'b1;
                        n_mode = M_NUM;
                        if (is_digit(c)) begin
                            n_len = sat_add(r_len, 2'd2);
                        end else begin
                            res[0] = mk(REC_TOKEN, K_FLOAT, r_tline, r_tcol,
                                        sat_add(r_len, 2'd1), '0);
                            nres = 2'd1;
                            again = 1'b1;
                        end
                    end
                end
                M_NUM: begin
                    if (is_digit(c)) begin
                        n_len = sat_add(r_len, 2'd1);
                    end else if (c == "." && !r_point) begin
                        n_mode = M_NUM_DOT;
                        n_held = ".";
                    end else begin
                        res[0] = mk(REC_TOKEN, r_point ? K_FLOAT : K_INTEGER, r_tline, r_tcol,
                                    r_len, '0);
                        nres = 2'd1;
                        again = 1'b1;
                    end
                end
                M_WORD: begin
                    if (is_alpha(c) || is_digit(c) || c == "_") begin
                        if (r_len < 16'(KB)) n_word[8*r_len[KBW-1:0] +: 8] = c;
                        else n_long = 1'b1;
                        n_len = sat_add(r_len, 2'd1);
                    end else begin
                        res[0] = mk(REC_TOKEN, word_kind, r_tline, r_tcol, r_len, '0);
                        nres = 2'd1;
                        again = 1'b1;
                    end
                end
                M_STR: begin
                    if (r_esc) begin
                        d = (c == "n") ? 8'd10 : (c == "t") ? 8'd9 : (c == "r") ? 8'd13 : c;
                        res[0] = mk(REC_VALUE, '0, '0, '0, '0, d);
                        nres = 2'd1;
                        n_len = sat_add(r_len, 2'd1);
                        n_esc = 1'b0;
                    end else if (c == (r_single ? 8'h27 : 8'h22)) begin
                        res[0] = mk(REC_TOKEN, K_STRING, r_tline, r_tcol, sat_add(r_len, 2'd2),
                                    '0);
                        nres = 2'd1;
                        n_mode = M_IDLE;
                    end else if (c == 8'h5c) begin
                        n_esc = 1'b1;
                    end else begin
                        res[0] = mk(REC_VALUE, '0, '0, '0, '0, c);
                        nres = 2'd1;
                        n_len = sat_add(r_len, 2'd1);
                    end
                end
                default: again = 1'b1;
            endcase

            // a byte that begins a token
            if (again) begin
                n_mode = M_IDLE;
                n_tline = r_line;
                n_tcol = r_col;
                sk = single_kind(c);
                if (c == " " || c == "\t" || c == "\r" || c == "\n") begin
                    n_mode = M_IDLE;
                end else if (c == "/" || c == "-" || c == "=" || c == "!" || c == "<" ||
                             c == ">" || c == "&" || c == "|") begin
                    n_mode = M_HOLD;
                    n_held = c;
                end else if (c == 8'h22 || c == 8'h27) begin
                    n_mode = M_STR;
                    n_single = c == 8'h27;
                    n_esc = 1'b0;
                    n_len = '0;
                end else if (is_digit(c)) begin
                    n_mode = M_NUM;
                    n_point = 1'b0;
                    n_len = 16'd1;
                end else if (is_alpha(c) || c == "_") begin
                    n_mode = M_WORD;
                    n_word = '0;
                    n_word[7:0] = c;
                    n_long = 1'b0;
                    n_len = 16'd1;
                end else begin
                    res[nres] = mk(REC_TOKEN, (sk == 8'd255) ? K_UNKNOWN : sk[5:0], r_line,
                                   r_col, 16'd1, '0);
                    nres = nres + 2'd1;
                end
            end

            // position advance
            if (c == "\n") begin
                if (r_line != LINE_MAX) n_line = r_line + 1'b1;
                n_col = COLUMN_WIDTH'(1);
            end else if (r_col != COL_MAX) begin
                n_col = r_col + 1'b1;
            end
        end

        if (nres != 2'd0) res[nres - 2'd1].last_of_run = 1'b1;
    end

    // queue update: pop head on output handshake, append new results behind
    always_comb begin
        logic [1:0] base;
        n_q = r_q;
        base = r_cnt;
        if (o_valid && i_ready) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            base = r_cnt - 2'd1;
        end
        n_cnt = base;
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < nres) n_q[base + 2'(i)] = res[i];
            end
            n_cnt = base + nres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_held <= '0;
            r_line <= LINE_WIDTH'(1);
            r_col <= COLUMN_WIDTH'(1);
            r_tline <= LINE_WIDTH'(1);
            r_tcol <= COLUMN_WIDTH'(1);
            r_len <= '0;
            r_word <= '0;
            r_long <= 1'b0;
            r_point <= 1'b0;
            r_esc <= 1'b0;
            r_single <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (accept) begin
                r_mode <= n_mode;
                r_held <= n_held;
                r_line <= n_line;
                r_col <= n_col;
                r_tline <= n_tline;
                r_tcol <= n_tcol;
                r_len <= n_len;
                r_word <= n_word;
                r_long <= n_long;
                r_point <= n_point;
                r_esc <= n_esc;
                r_single <= n_single;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    // a waiting output item holds still until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("output item moved");
    // input is refused while two or more results wait
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt >= 2'd2 |-> !o_ready) else $error("accept with full queue");
    // an end command always leaves the scanner idle
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_data.command == CMD_END |=> r_mode == M_IDLE) else $error("end not idle");
    // counts never read zero
    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0 && r_col != '0) else $error("position zero");

endmodule

>>> dv/source_text_tokenizer_checker.sv
// checker that predicts and compares tokenizer output items
`timescale 1ns / 1ps
module source_text_tokenizer_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_ready,
    input  stt_pkg::t_in   i_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  stt_pkg::t_out  i_out_data,
    output int             o_fail_count,
    output int             o_pending
);
    import stt_pkg::*;

    localparam int KW_BYTES = 6;
    localparam logic [19:0] LINE_TOP = 20'hFFFFF;
    localparam logic [15:0] COL_TOP  = 16'hFFFF;

    t_mode       mode;
    logic [7:0]  hold_ch;
    logic [19:0] cur_line, tok_line;
    logic [15:0] cur_col, tok_col, tok_len;
    logic [7:0]  word_q [KW_BYTES];
    logic        too_long, has_point, esc_pending, single_quote;
    t_out        token_queue [$];
    t_out        step_out [$];

    string kw_names [16] = '{"int", "float", "double", "bool", "char", "void",
        "return", "if", "else", "for", "while", "struct", "enum", "fn",
        "true", "false"};

    function automatic logic [15:0] len_add(logic [15:0] a, int b);
        int s;
        s = a + b;
        return (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [5:0] lone_kind(logic [7:0] c);
        case (c)
            "(": return 6'd16;  ")": return 6'd17;  "{": return 6'd18;
            "}": return 6'd19;  "[": return 6'd20;  "]": return 6'd21;
            ";": return 6'd22;  ":": return 6'd23;  ",": return 6'd24;
            ".": return K_DOT;  "~": return 6'd26;  "+": return 6'd27;
            "*": return 6'd30;  "%": return 6'd32;  "^": return 6'd45;
            default: return K_UNKNOWN;
        endcase
    endfunction

    function automatic logic letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void emit(logic rk, logic [5:0] k, logic [19:0] ln, logic [15:0] col,
                                 logic [15:0] len, logic [7:0] vb);
        t_out r;
        r = '0;
        r.record_kind = rk;
        r.token_kind = k;
        r.start_line = ln;
        r.start_column = col;
        r.lexeme_length = len;
        r.value_byte = vb;
        step_out = {step_out, r};
    endfunction

    function automatic logic [5:0] keyword_of();
        string w;
        w = "";
        if (too_long || tok_len > KW_BYTES) return K_IDENT;
        for (int i = 0; i < tok_len; i++) w = {w, string'(word_q[i])};
        for (int i = 0; i < 16; i++)
            if (kw_names[i] == w) return 6'(i);
        return K_IDENT;
    endfunction

    task automatic word_push(logic [7:0] c);
        if (tok_len < KW_BYTES) word_q[tok_len] = c;
        else too_long = 1'b1;
        tok_len = len_add(tok_len, 1);
    endtask

    task automatic clear_state();
        mode = M_IDLE;
        hold_ch = '0;
        cur_line = 1;
        cur_col = 1;
        tok_line = 1;
        tok_col = 1;
        tok_len = '0;
        foreach (word_q[i]) word_q[i] = '0;
        too_long = 0;
        has_point = 0;
        esc_pending = 0;
        single_quote = 0;
    endtask

    // byte seen between tokens
    task automatic open_token(logic [7:0] c, logic [19:0] ln, logic [15:0] col);
        mode = M_IDLE;
        tok_line = ln;
        tok_col = col;
        if (c inside {" ", 8'h09, 8'h0D, 8'h0A}) return;
        if (c inside {"/", "-", "=", "!", "<", ">", "&", "|"}) begin
            mode = M_HOLD;
            hold_ch = c;
        end else if (c == 8'h22 || c == 8'h27) begin
            mode = M_STR;
            single_quote = (c == 8'h27);
            esc_pending = 0;
            tok_len = 0;
        end else if (digit(c)) begin
            mode = M_NUM;
            has_point = 0;
            tok_len = 1;
        end else if (letter(c) || c == "_") begin
            mode = M_WORD;
            foreach (word_q[i]) word_q[i] = '0;
            too_long = 0;
            tok_len = 0;
            word_push(c);
        end else begin
            emit(REC_TOKEN, lone_kind(c), ln, col, 1, 0);
        end
    endtask

    // held operator against next byte; c > 255 means end of source
    function automatic logic settle_hold(int c);
        int pair;
        logic [5:0] two, one;
        if (hold_ch == "/") begin
            if (c == "/") begin mode = M_LINE; return 0; end
            if (c == "*") begin mode = M_BLOCK; return 0; end
            emit(REC_TOKEN, K_SLASH, tok_line, tok_col, 1, 0);
            return 1;
        end
        case (hold_ch)
            "-": begin pair = ">"; two = 6'd28; one = 6'd29; end
            "=": begin pair = "="; two = 6'd33; one = 6'd34; end
            "!": begin pair = "="; two = 6'd35; one = 6'd36; end
            "<": begin pair = "="; two = 6'd37; one = 6'd38; end
            ">": begin pair = "="; two = 6'd39; one = 6'd40; end
            "&": begin pair = "&"; two = 6'd41; one = 6'd42; end
            default: begin pair = "|"; two = 6'd43; one = 6'd44; end
        endcase
        if (c == pair) begin
            emit(REC_TOKEN, two, tok_line, tok_col, 2, 0);
            mode = M_IDLE;
            return 0;
        end
        emit(REC_TOKEN, one, tok_line, tok_col, 1, 0);
        return 1;
    endfunction

    task automatic predict_item(t_in it);
        logic [7:0] c, d;
        logic [19:0] ln;
        logic [15:0] col;
        logic again;
        int dcol;
        c = it.char_byte;
        ln = cur_line;
        col = cur_col;
        again = 0;
        step_out.delete();
        if (it.command == CMD_END) begin
            case (mode)
                M_HOLD: void'(settle_hold(256));
                M_NUM: emit(REC_TOKEN, has_point ? K_FLOAT : K_INTEGER, tok_line, tok_col,
                            tok_len, 0);
                M_NUM_DOT: emit(REC_TOKEN, K_FLOAT, tok_line, tok_col, len_add(tok_len, 1), 0);
                M_WORD: emit(REC_TOKEN, keyword_of(), tok_line, tok_col, tok_len, 0);
                M_STR: emit(REC_TOKEN, K_UNTERM, tok_line, tok_col, len_add(tok_len, 1), 0);
                default: ;
            endcase
            emit(REC_TOKEN, K_EOF, cur_line, cur_col, 0, 0);
            clear_state();
        end else begin
            case (mode)
                M_IDLE: open_token(c, ln, col);
                M_HOLD: again = settle_hold(c);
                M_LINE: if (c == 8'h0A) mode = M_IDLE;
                M_BLOCK: if (c == "*") mode = M_BLOCK_STAR;
                M_BLOCK_STAR: begin
                    if (c == "/") mode = M_IDLE;
                    else if (c != "*") mode = M_BLOCK;
                end
                M_NUM, M_NUM_DOT: begin
                    if (mode == M_NUM_DOT && c == ".") begin
                        // dot dot: integer then a dot token, then the new dot
                        emit(REC_TOKEN, K_INTEGER, tok_line, tok_col, tok_len, 0);
                        dcol = tok_col + tok_len;
                        if (dcol > COL_TOP) dcol = COL_TOP;
                        emit(REC_TOKEN, K_DOT, tok_line, 16'(dcol), 1, 0);
                        again = 1;
                    end else begin
                        if (mode == M_NUM_DOT) begin
                            has_point = 1;
                            tok_len = len_add(tok_len, 1);
                            mode = M_NUM;
                        end
                        if (digit(c)) tok_len = len_add(tok_len, 1);
                        else if (c == "." && !has_point) begin
                            mode = M_NUM_DOT;
                            hold_ch = ".";
                        end else begin
                            emit(REC_TOKEN, has_point ? K_FLOAT : K_INTEGER, tok_line,
                                 tok_col, tok_len, 0);
                            again = 1;
                        end
                    end
                end
                M_WORD: begin
                    if (letter(c) || digit(c) || c == "_") word_push(c);
                    else begin
                        emit(REC_TOKEN, keyword_of(), tok_line, tok_col, tok_len, 0);
                        again = 1;
                    end
                end
                M_STR: begin
                    if (esc_pending) begin
                        d = (c == "n") ? 8'd10 : (c == "t") ? 8'd9 : (c == "r") ? 8'd13 : c;
                        emit(REC_VALUE, 0, 0, 0, 0, d);
                        tok_len = len_add(tok_len, 1);
                        esc_pending = 0;
                    end else if (c == (single_quote ? 8'h27 : 8'h22)) begin
                        emit(REC_TOKEN, K_STRING, tok_line, tok_col, len_add(tok_len, 2), 0);
                        mode = M_IDLE;
                    end else if (c == 8'h5C) begin
                        esc_pending = 1;
                    end else begin
                        emit(REC_VALUE, 0, 0, 0, 0, c);
                        tok_len = len_add(tok_len, 1);
                    end
                end
                default: again = 1;
            endcase
            if (again) open_token(c, ln, col);
            if (c == 8'h0A) begin
                if (cur_line < LINE_TOP) cur_line++;
                cur_col = 1;
            end else if (cur_col < COL_TOP) begin
                cur_col++;
            end
        end
        if (step_out.size() > 0) step_out[step_out.size()-1].last_of_run = 1'b1;
        foreach (step_out[i]) token_queue = {token_queue, step_out[i]};
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            clear_state();
            token_queue.delete();
        end else begin
            if (i_valid && i_ready) predict_item(i_data);
            if (i_out_valid && i_out_ready) begin
                if (token_queue.size() == 0) begin
                    $error("unexpected output item: %p", i_out_data);
                    o_fail_count++;
                end else begin
                    exp_r = token_queue.pop_front();
                    check_field("record_kind", exp_r.record_kind, i_out_data.record_kind);
                    check_field("token_kind", exp_r.token_kind, i_out_data.token_kind);
                    check_field("start_line", exp_r.start_line, i_out_data.start_line);
                    check_field("start_column", exp_r.start_column, i_out_data.start_column);
                    check_field("lexeme_length", exp_r.lexeme_length,
                                i_out_data.lexeme_length);
                    check_field("value_byte", exp_r.value_byte, i_out_data.value_byte);
                    check_field("last_of_run", exp_r.last_of_run, i_out_data.last_of_run);
                end
            end
        end
        o_pending <= token_queue.size();
    end

    initial o_fail_count = 0;
    initial o_pending = 0;

endmodule

>>> dv/tb.sv
// stimulus and verdict for the source text tokenizer
`timescale 1ns / 1ps
module tb;
    import stt_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic  clk = 0;
    logic  rst_n = 0;
    logic  in_valid = 0;
    logic  in_ready;
    t_in   in_data = '0;
    logic  out_valid;
    logic  out_ready = 0;
    t_out  out_data;
    int    fail_count;
    int    pending;
    int    send_idle_pct = 30;   // chance per cycle that the sender pauses
    int    recv_idle_pct = 60;   // chance per cycle that the receiver stalls
    int    quiet_cycles = 0;
    logic  timed_out = 0;

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    source_text_tokenizer u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_data(in_data),
        .o_valid(out_valid), .i_ready(out_ready), .o_data(out_data)
    );

    source_text_tokenizer_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_ready(in_ready), .i_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stalls at random, changed on the falling edge
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: counts cycles with no item moving on either channel
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("source_text_tokenizer regression: fail");
            $finish;
        end
    end

    int sent = 0;

    // one item: optional idle gap, then hold valid until accepted
    task automatic send(logic cmd, logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        in_data <= '{command: cmd, char_byte: ch};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send(CMD_BYTE, s[i]);
    endtask

    // well-formed-ish random fragment with random content
    task automatic send_fragment();
        string ops [] = '{"->", "==", "!=", "<=", ">=", "&&", "||", "/", "-", "=", "!",
                          "<", ">", "&", "|", "(", ")", ";", ".", "+", "*", "%", "^"};
        string words [] = '{"int", "float", "double", "bool", "char", "void", "return",
                            "if", "else", "for", "while", "struct", "enum", "fn", "true",
                            "false", "x_1", "returns", "_a", "Fn"};
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: send_text(words[$urandom_range(words.size()-1)]);
            1: send_text(ops[$urandom_range(ops.size()-1)]);
            2: begin
                send_text($sformatf("%0d", $urandom_range(999)));
                if ($urandom_range(1)) send_text($sformatf(".%0d", $urandom_range(99)));
            end
            3: begin
                send(CMD_BYTE, $urandom_range(1) ? 8'h22 : 8'h27);
                repeat ($urandom_range(4)) begin
                    if ($urandom_range(3) == 0) send(CMD_BYTE, 8'h5C);
                    send(CMD_BYTE, 8'($urandom_range(255)));
                end
                send(CMD_BYTE, $urandom_range(1) ? 8'h22 : 8'h27);
            end
            4: send_text("// c\n");
            5: send_text("/* * */");
            6: send(CMD_BYTE, 8'($urandom_range(255)));
            7: send_text("1..2");
            8: if ($urandom_range(3) == 0) send(CMD_END, 8'($urandom_range(255)));
            default: send(CMD_BYTE, $urandom_range(1) ? 8'h0A : 8'h20);
        endcase
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: operators, keywords, numbers, strings, comments, ends
        send_text("while(fn->x<=3.5){");
        send(CMD_BYTE, 8'hFF);
        send(CMD_BYTE, 8'h00);
        send_text("7..x\n");
        send(CMD_END, 8'hFF);
        send_text("\"a\\n\\q\"'b' struct1 /");
        send(CMD_END, 8'h00);
        send_text("12.");
        send(CMD_END, 8'h00);
        send_text("'x\\");
        send(CMD_END, 8'h00);
        send_text("/*open");
        send(CMD_END, 8'h00);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 60 : 0;
            recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 30 : 0;
            while (sent < 40 + 50 * (ph + 1)) send_fragment();
            send(CMD_END, 8'h00);
        end
        in_valid <= 0;

        while (pending > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("source_text_tokenizer regression: pass");
        else
            $display("source_text_tokenizer regression: fail");
        $finish;
    end

endmodule
